// File: hdl/aurc_pkg.sv
// shared types and constants of the arp/udp receive classifier
package aurc_pkg;

  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_OPEN  = 2'd1;
  localparam logic [1:0] REQ_CLOSE = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
  localparam logic [2:0] KIND_DROPPED  = 3'd1;
  localparam logic [2:0] KIND_ARP_REPLY = 3'd2;
  localparam logic [2:0] KIND_RESOLVED = 3'd3;
  localparam logic [2:0] KIND_UDP_DONE = 3'd4;
  localparam logic [2:0] KIND_OPENED   = 3'd5;
  localparam logic [2:0] KIND_FULL     = 3'd6;

  localparam logic [15:0] ETH_IPV4     = 16'h0800;
  localparam logic [15:0] ETH_ARP      = 16'h0806;
  localparam logic [7:0]  PROTO_UDP    = 8'h11;
  localparam logic [15:0] ARP_OP_REPLY = 16'h0002;
  localparam logic [15:0] PAYLOAD_START = 16'd42;
  localparam logic [15:0] UDP_HDR_LEN  = 16'd8;
  localparam logic [15:0] POS_MAX      = 16'hFFFF;

  localparam logic [31:0] LOCAL_IP_RESET  = 32'h0A00_0002;
  localparam logic [15:0] PORT_BASE_RESET = 16'd3000;

  localparam logic CFG_LOCAL_IP  = 1'b0;
  localparam logic CFG_PORT_BASE = 1'b1;

  typedef enum logic [2:0] {
    CMD_EMIT     = 3'd0,
    CMD_PAY_DONE = 3'd1,
    CMD_OPEN     = 3'd2,
    CMD_CLOSE    = 3'd3,
    CMD_ARP      = 3'd4
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e     op;
    logic [2:0]  kind;
    logic [6:0]  slot;
    logic [7:0]  data;
    logic [47:0] mac;
    logic [31:0] addr;
    logic [15:0] len;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [6:0]  slot;
    logic [7:0]  data;
    logic [47:0] mac;
    logic [31:0] addr;
    logic [15:0] len;
    logic        last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } back_state_e;

endpackage

// File: hdl/arp_udp_receive_classifier_core.sv
// top level of the arp/udp receive classifier
// Requests enter through a queue-style port: push with full, one word per
// accepted edge. req_type selects a frame byte, an open or a close request.
// Results leave through empty and pop; the oldest result sits on the output
// ports while empty is low. Each frame ends in one summary word, and any
// streamed payload bytes come before it. Configuration (local_ip, port_base)
// is written through cfg_valid_i/cfg_ready_o; the user must write it only
// while the block is idle, the block itself does not enforce it. Payload
// words pass through the command queue and the result register and stream
// at one per cycle while the back end is idle and pop keeps up. An open
// request scans the slot table one slot a cycle; an arp reply to us scans
// the peer address memory one slot a cycle. During a scan frame bytes keep
// queueing until the four-entry command queue fills; at byte 37 of a frame
// input waits for the table to settle. Reset empties the queue and marks
// every slot free; no clearing pass. A stalled receiver holds the result
// register and then the queue backs up to full.
module arp_udp_receive_classifier_core #(
  parameter int SLOTS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  frame_byte_i,
  input  logic        end_of_frame_i,
  input  logic [6:0]  close_slot_i,
  input  logic [31:0] peer_ip_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind_o,
  output logic [6:0]  slot_o,
  output logic [7:0]  data_byte_o,
  output logic [47:0] peer_mac_o,
  output logic [31:0] peer_addr_o,
  output logic [15:0] payload_len_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import aurc_pkg::*;

  logic [31:0]      local_ip_q;
  logic [15:0]      port_base_q;
  logic             accept, at_match, cmd_wr, q_full, q_empty, deq, idle, out_valid;
  logic [SLOTS-1:0] slot_open;
  cmd_t             cmd, head;
  res_t             res;

  assign cfg_ready_o = 1'b1;
  assign full   = q_full || (at_match && !idle);
  assign accept = push && !full;
  assign empty  = !out_valid;

  assign kind_o        = res.kind;
  assign slot_o        = res.slot;
  assign data_byte_o   = res.data;
  assign peer_mac_o    = res.mac;
  assign peer_addr_o   = res.addr;
  assign payload_len_o = res.len;
  assign last_o        = res.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ip_q  <= LOCAL_IP_RESET;
      port_base_q <= PORT_BASE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LOCAL_IP:  local_ip_q  <= cfg_data_i;
        CFG_PORT_BASE: port_base_q <= cfg_data_i[15:0];
        default:       local_ip_q  <= local_ip_q;
      endcase
    end
  end

  aurc_front #(.SLOTS(SLOTS)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .req_type_i     (req_type_i),
    .frame_byte_i   (frame_byte_i),
    .end_of_frame_i (end_of_frame_i),
    .close_slot_i   (close_slot_i),
    .peer_ip_i      (peer_ip_i),
    .local_ip_i     (local_ip_q),
    .port_base_i    (port_base_q),
    .slot_open_i    (slot_open),
    .at_match_o     (at_match),
    .cmd_wr_o       (cmd_wr),
    .cmd_o          (cmd)
  );

  aurc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_wr),
    .wdata_i (cmd),
    .rd_i    (deq),
    .head_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  aurc_back #(.SLOTS(SLOTS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_empty_i   (q_empty),
    .deq_o       (deq),
    .idle_o      (idle),
    .slot_open_o (slot_open),
    .pop_i       (pop),
    .out_valid_o (out_valid),
    .out_o       (res)
  );
endmodule

// File: hdl/aurc_ram.sv
// generic single write, single registered read memory
module aurc_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: hdl/aurc_fifo.sv
// short command queue between front and back
module aurc_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  aurc_pkg::cmd_t wdata_i,
  input  logic          rd_i,
  output aurc_pkg::cmd_t head_o,
  output logic          full_o,
  output logic          empty_o
);
  import aurc_pkg::*;

  cmd_t       ent_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;

  assign head_o  = ent_q[rp_q];
  assign full_o  = cnt_q == 3'd4;
  assign empty_o = cnt_q == 3'd0;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      ent_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + 2'd1;
      if (rd_i) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'b0, wr_i} - {2'b0, rd_i};
    end
  end
endmodule

// File: hdl/aurc_front.sv
// frame parser and request classifier feeding the command queue
module aurc_front #(
  parameter int SLOTS = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [1:0]          req_type_i,
  input  logic [7:0]          frame_byte_i,
  input  logic                end_of_frame_i,
  input  logic [6:0]          close_slot_i,
  input  logic [31:0]         peer_ip_i,
  input  logic [31:0]         local_ip_i,
  input  logic [15:0]         port_base_i,
  input  logic [SLOTS-1:0]    slot_open_i,
  output logic                at_match_o,
  output logic                cmd_wr_o,
  output aurc_pkg::cmd_t      cmd_o
);
  import aurc_pkg::*;

  localparam int IW = SLOTS > 1 ? $clog2(SLOTS) : 1;

  logic [15:0] pos_q, pos_d;
  logic        match_q, match_d;
  logic [6:0]  mslot_q, mslot_d;
  logic [15:0] eth_q, eth_d, port_q, port_d, ulen_q, ulen_d, op_q, op_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] iptgt_q, iptgt_d, sip_q, sip_d, tip_q, tip_d;
  logic [47:0] mac_q, mac_d;
  logic [15:0] slot_off, pay_cnt;
  logic        is_byte, pay;

  assign at_match_o = pos_q == 16'd37;
  assign is_byte    = req_type_i == REQ_BYTE;
  assign slot_off   = port_d - port_base_i;
  assign pay_cnt    = ulen_d >= UDP_HDR_LEN ? ulen_d - UDP_HDR_LEN : 16'd0;

  always_comb begin
    logic clr;
    clr = pos_q == 16'd0;
    eth_d   = clr ? '0 : eth_q;
    port_d  = clr ? '0 : port_q;
    ulen_d  = clr ? '0 : ulen_q;
    op_d    = clr ? '0 : op_q;
    proto_d = clr ? '0 : proto_q;
    iptgt_d = clr ? '0 : iptgt_q;
    sip_d   = clr ? '0 : sip_q;
    tip_d   = clr ? '0 : tip_q;
    mac_d   = clr ? '0 : mac_q;
    match_d = clr ? 1'b0 : match_q;
    mslot_d = clr ? '0 : mslot_q;
    if (pos_q == 16'd12 || pos_q == 16'd13) eth_d = {eth_d[7:0], frame_byte_i};
    if (pos_q == 16'd23) proto_d = frame_byte_i;
    if (pos_q >= 16'd30 && pos_q <= 16'd33) iptgt_d = {iptgt_d[23:0], frame_byte_i};
    if (pos_q == 16'd36 || pos_q == 16'd37) port_d = {port_d[7:0], frame_byte_i};
    if (pos_q == 16'd38 || pos_q == 16'd39) ulen_d = {ulen_d[7:0], frame_byte_i};
    if (pos_q == 16'd20 || pos_q == 16'd21) op_d = {op_d[7:0], frame_byte_i};
    if (pos_q >= 16'd22 && pos_q <= 16'd27) mac_d = {mac_d[39:0], frame_byte_i};
    if (pos_q >= 16'd28 && pos_q <= 16'd31) sip_d = {sip_d[23:0], frame_byte_i};
    if (pos_q >= 16'd38 && pos_q <= 16'd41) tip_d = {tip_d[23:0], frame_byte_i};
    if (pos_q == 16'd37 && eth_d == ETH_IPV4 && iptgt_d == local_ip_i &&
        proto_d == PROTO_UDP && {16'd0, slot_off} < SLOTS) begin
      if (slot_open_i[slot_off[IW-1:0]]) begin
        match_d = 1'b1;
        mslot_d = slot_off[6:0];
      end
    end
    pay = match_d && pos_q >= PAYLOAD_START && pos_q < POS_MAX &&
          (pos_q - PAYLOAD_START) < pay_cnt;
    if (end_of_frame_i) begin
      pos_d = '0;
    end else begin
      pos_d = pos_q == POS_MAX ? POS_MAX : pos_q + 16'd1;
    end
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.op   = CMD_EMIT;
    cmd_wr_o   = 1'b0;
    unique case (req_type_i)
      REQ_BYTE: begin
        if (end_of_frame_i) begin
          cmd_wr_o = 1'b1;
          if (match_d) begin
            cmd_o.slot = mslot_d;
            cmd_o.len  = pay_cnt;
            cmd_o.kind = KIND_UDP_DONE;
            if (pay) begin
              cmd_o.op   = CMD_PAY_DONE;
              cmd_o.data = frame_byte_i;
            end
          end else if (eth_d == ETH_ARP && pos_q >= 16'd41 && tip_d == local_ip_i) begin
            cmd_o.mac  = mac_d;
            cmd_o.addr = sip_d;
            if (op_d == ARP_OP_REPLY) begin
              cmd_o.op = CMD_ARP;
            end else begin
              cmd_o.kind = KIND_ARP_REPLY;
            end
          end else begin
            cmd_o.kind = KIND_DROPPED;
          end
        end else if (pay) begin
          cmd_wr_o   = 1'b1;
          cmd_o.kind = KIND_PAYLOAD;
          cmd_o.slot = mslot_d;
          cmd_o.data = frame_byte_i;
        end
      end
      REQ_OPEN: begin
        cmd_wr_o   = 1'b1;
        cmd_o.op   = CMD_OPEN;
        cmd_o.addr = peer_ip_i;
      end
      REQ_CLOSE: begin
        cmd_wr_o   = 1'b1;
        cmd_o.op   = CMD_CLOSE;
        cmd_o.slot = close_slot_i;
      end
      default: cmd_wr_o = 1'b0;
    endcase
    cmd_wr_o = cmd_wr_o && accept_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      match_q <= 1'b0;
    end else if (accept_i && is_byte) begin
      pos_q   <= pos_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && is_byte) begin
      mslot_q <= mslot_d;
      eth_q   <= eth_d;
      port_q  <= port_d;
      ulen_q  <= ulen_d;
      op_q    <= op_d;
      proto_q <= proto_d;
      iptgt_q <= iptgt_d;
      sip_q   <= sip_d;
      tip_q   <= tip_d;
      mac_q   <= mac_d;
    end
  end
endmodule

// File: hdl/aurc_back.sv
// slot table engine and result register
module aurc_back #(
  parameter int SLOTS = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  aurc_pkg::cmd_t   head_i,
  input  logic             q_empty_i,
  output logic             deq_o,
  output logic             idle_o,
  output logic [SLOTS-1:0] slot_open_o,
  input  logic             pop_i,
  output logic             out_valid_o,
  output aurc_pkg::res_t   out_o
);
  import aurc_pkg::*;

  localparam int IW = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  back_state_e      state_q, state_d;
  logic [SLOTS-1:0] open_q, open_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             chk_v_q, chk_v_d;
  logic [IW-1:0]    chk_idx_q;
  cmd_t             cmd_q, cmd_d;
  res_t             res_q, res_d, out_q, out_d;
  logic             out_valid_q, out_valid_d, out_free;
  logic             ram_we;
  logic [31:0]      ram_rdata;
  logic [IW-1:0]    cur_idx;

  assign out_free    = !out_valid_q || pop_i;
  assign cur_idx     = cnt_q[IW-1:0];
  assign idle_o      = state_q == ST_IDLE && q_empty_i;
  assign slot_open_o = open_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  aurc_ram #(.Width(32), .Depth(SLOTS)) u_peer_ip (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_idx),
    .wdata_i (cmd_q.addr),
    .raddr_i (cur_idx),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    open_d      = open_q;
    cnt_d       = cnt_q;
    chk_v_d     = 1'b0;
    cmd_d       = cmd_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !pop_i;
    deq_o       = 1'b0;
    ram_we      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          unique case (head_i.op)
            CMD_EMIT: begin
              if (out_free) begin
                deq_o       = 1'b1;
                out_valid_d = 1'b1;
                out_d       = {head_i.kind, head_i.slot, head_i.data, head_i.mac,
                               head_i.addr, head_i.len, 1'b1};
              end
            end
            CMD_PAY_DONE: begin
              if (out_free) begin
                deq_o       = 1'b1;
                out_valid_d = 1'b1;
                out_d       = {KIND_PAYLOAD, head_i.slot, head_i.data, 48'd0,
                               32'd0, 16'd0, 1'b0};
                res_d       = {KIND_UDP_DONE, head_i.slot, 8'd0, 48'd0,
                               32'd0, head_i.len, 1'b1};
                state_d     = ST_EMIT;
              end
            end
            CMD_CLOSE: begin
              deq_o = 1'b1;
              if (int'(head_i.slot) < SLOTS) open_d[head_i.slot[IW-1:0]] = 1'b0;
            end
            CMD_OPEN, CMD_ARP: begin
              deq_o   = 1'b1;
              cmd_d   = head_i;
              cnt_d   = '0;
              state_d = ST_SCAN;
            end
            default: deq_o = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        if (cmd_q.op == CMD_OPEN) begin
          if (!open_q[cur_idx]) begin
            open_d[cur_idx] = 1'b1;
            ram_we  = 1'b1;
            res_d   = {KIND_OPENED, 7'(cur_idx), 8'd0, 48'd0, cmd_q.addr, 16'd0, 1'b1};
            state_d = ST_EMIT;
          end else if (cnt_q == CW'(SLOTS - 1)) begin
            res_d   = {KIND_FULL, 7'd0, 8'd0, 48'd0, 32'd0, 16'd0, 1'b1};
            state_d = ST_EMIT;
          end else begin
            cnt_d = cnt_q + CW'(1);
          end
        end else begin
          if (cnt_q < CW'(SLOTS)) begin
            chk_v_d = 1'b1;
            cnt_d   = cnt_q + CW'(1);
          end
          if (chk_v_q && open_q[chk_idx_q] && ram_rdata == cmd_q.addr) begin
            res_d   = {KIND_RESOLVED, 7'(chk_idx_q), 8'd0, cmd_q.mac, cmd_q.addr,
                       16'd0, 1'b1};
            state_d = ST_EMIT;
          end else if (chk_v_q && chk_idx_q == IW'(SLOTS - 1)) begin
            res_d   = {KIND_DROPPED, 7'd0, 8'd0, 48'd0, 32'd0, 16'd0, 1'b1};
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      open_q      <= '0;
      out_valid_q <= 1'b0;
      chk_v_q     <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      open_q      <= open_d;
      out_valid_q <= out_valid_d;
      chk_v_q     <= chk_v_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= cur_idx;
    cmd_q     <= cmd_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  a_deq_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_o |-> state_q == ST_IDLE)
    else $error("queue read outside idle");
  a_we_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == ST_SCAN && cmd_q.op == CMD_OPEN && !open_q[cur_idx])
    else $error("peer write without free slot");
  a_we_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> state_q == ST_EMIT && res_q.kind == KIND_OPENED)
    else $error("open did not report");
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state not one-hot");
endmodule
